@@ rtl/pulse_start_and_width_finder_macros.svh @@
// Assertion macros for the pulse start and width finder.
// Define ASSERT_OFF to compile the checks out.
`ifndef PULSE_START_AND_WIDTH_FINDER_MACROS_SVH
`define PULSE_START_AND_WIDTH_FINDER_MACROS_SVH

`ifndef ASSERT_OFF

// Antecedent in this cycle implies consequent in the same cycle.
`define PSWF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse finder check failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define PSWF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse finder check failed");

`else

`define PSWF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PSWF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/pswf_pkg.sv @@
`timescale 1ns / 1ps

package pswf_pkg;

    // Samples per timing word
    localparam int WORD_BITS      = 32;
    // Zero counts run 0..32
    localparam int ZCNT_BITS      = 6;
    // Reported count fields
    localparam int FIELD_BITS     = 12;
    // Default counter width
    localparam int COUNT_BITS_DEF = 12;
    // Output tdata: start, width, seen, padded to whole bytes
    localparam int RESULT_BITS    = 2 * FIELD_BITS + 1;
    localparam int OUT_DATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [ZCNT_BITS-1:0] lead;   // zeros above the highest set bit
        logic [ZCNT_BITS-1:0] trail;  // zeros below the lowest set bit
    } zcount_t;

endpackage

@@ rtl/pulse_start_and_width_finder.sv @@
`timescale 1ns / 1ps
`include "pulse_start_and_width_finder_macros.svh"

// Pulse start and width finder. Each request on the slave stream is one 32-bit
// timing word (MSB earliest) with tlast marking the final word of an event.
// Before the pulse, words add their leading zeros to the start count; the first
// nonzero word opens the width, and later words add 32 minus their trailing
// zeros. On the last word one result (start, width, seen) is sent on the master
// stream and the counters clear. It takes one word per clock while not stalled;
// a result passes the input register, then the result register. The single loop
// is the counter update, one zero-count encode plus a saturating add per cycle.
// The input stalls only when a last word finds the result register still held.
module pulse_start_and_width_finder
    import pswf_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [WORD_BITS-1:0]     s_axis_tdata,   // [31:0] sample_word
    input  logic                     s_axis_tlast,   // last_word
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [11:0] pulse_start, [23:12] pulse_width, [24] pulse_seen, rest zero
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Input register
    logic                  in_valid_reg;
    logic [WORD_BITS-1:0]  in_word_reg;
    logic                  in_last_reg;

    // Event state
    logic                  seen_reg,  seen_next;
    logic [COUNT_BITS-1:0] start_reg, start_next;
    logic [COUNT_BITS-1:0] width_reg, width_next;

    // Result register
    logic                  out_valid_reg;
    logic [FIELD_BITS-1:0] out_start_reg;
    logic [FIELD_BITS-1:0] out_width_reg;
    logic                  out_seen_reg;

    zcount_t               zc;
    logic                  out_free;
    logic                  advance;
    logic                  upd_seen;
    logic [COUNT_BITS-1:0] upd_start;
    logic [COUNT_BITS-1:0] upd_width;
    logic [COUNT_BITS:0]   start_sum;
    logic [COUNT_BITS:0]   width_sum;
    logic [ZCNT_BITS-1:0]  width_inc;
    logic [COUNT_BITS+FIELD_BITS-1:0] start_ext;
    logic [COUNT_BITS+FIELD_BITS-1:0] width_ext;

    // Handshake: a word leaves the input register unless it is last and the
    // result register cannot take its result.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_word_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    pswf_zcount u_zcount
    (
        .word   (in_word_reg),
        .counts (zc)
    );

    // Counter update for the registered word
    assign width_inc = ZCNT_BITS'(WORD_BITS) - (seen_reg ? zc.trail : zc.lead);
    assign start_sum = {1'b0, start_reg} + (COUNT_BITS+1)'(zc.lead);
    assign width_sum = {1'b0, width_reg} + (COUNT_BITS+1)'(width_inc);

    always_comb
    begin
        upd_seen  = seen_reg;
        upd_start = start_reg;
        upd_width = width_reg;
        if (!seen_reg)
        begin
            upd_start = start_sum[COUNT_BITS] ? COUNT_MAX : start_sum[COUNT_BITS-1:0];
            if (in_word_reg != '0)
            begin
                // first nonzero word opens the pulse
                upd_seen  = 1'b1;
                upd_width = COUNT_BITS'(width_inc);
            end
        end
        else
        begin
            upd_width = width_sum[COUNT_BITS] ? COUNT_MAX : width_sum[COUNT_BITS-1:0];
        end
    end

    // Next state: clear after the last word of an event
    always_comb
    begin
        seen_next  = seen_reg;
        start_next = start_reg;
        width_next = width_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                seen_next  = 1'b0;
                start_next = '0;
                width_next = '0;
            end
            else
            begin
                seen_next  = upd_seen;
                start_next = upd_start;
                width_next = upd_width;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 1'b0;
            start_reg <= '0;
            width_reg <= '0;
        end
        else
        begin
            seen_reg  <= seen_next;
            start_reg <= start_next;
            width_reg <= width_next;
        end
    end

    // Reported fields are the low bits of the counters
    assign start_ext = {{FIELD_BITS{1'b0}}, upd_start};
    assign width_ext = {{FIELD_BITS{1'b0}}, upd_width};

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_start_reg <= start_ext[FIELD_BITS-1:0];
            out_width_reg <= width_ext[FIELD_BITS-1:0];
            out_seen_reg  <= upd_seen;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_BITS-RESULT_BITS)'(0),
                            out_seen_reg, out_width_reg, out_start_reg};

    // Checks
    `PSWF_ASSERT_SAME(a_no_width_unseen, clk, rst_n, out_valid_reg && !out_seen_reg, out_width_reg == '0)
    `PSWF_ASSERT_NEXT(a_clear_after_last, clk, rst_n, advance && in_last_reg, !seen_reg && start_reg == '0 && width_reg == '0)
    `PSWF_ASSERT_NEXT(a_last_held, clk, rst_n, in_valid_reg && in_last_reg && !out_free, in_valid_reg && in_last_reg)
    `PSWF_ASSERT_SAME(a_seen_needs_word, clk, rst_n, $rose(seen_reg), $past(in_word_reg) != '0)

endmodule

@@ rtl/pswf_zcount.sv @@
`timescale 1ns / 1ps

// Leading and trailing zero counts of one timing word; 32 for a zero word.
module pswf_zcount
    import pswf_pkg::*;
(
    input  logic [WORD_BITS-1:0] word,
    output zcount_t              counts
);

    // Leading zeros: highest set bit wins
    always_comb
    begin
        counts.lead = ZCNT_BITS'(WORD_BITS);
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (word[i])
            begin
                counts.lead = ZCNT_BITS'(WORD_BITS - 1 - i);
            end
        end
    end

    // Trailing zeros: lowest set bit wins
    always_comb
    begin
        counts.trail = ZCNT_BITS'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                counts.trail = ZCNT_BITS'(i);
            end
        end
    end

endmodule
